// ===== design/llss_pkg.sv =====
// package for least_loaded_server_select: codes, widths, state and table entry types
package llss_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int CMD_W           = 2;
    localparam int IDX_W           = 4;
    localparam int CNT_W           = 32;
    localparam int CFG_W           = 5;

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DONE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;
    // the fourth command code has no meaning and is ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [CFG_W-1:0] SERVERS_IN_USE_RST = 5'd1;
    localparam logic [CNT_W-1:0] COUNT_MAX          = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DONE_WR,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] req;
        logic [CNT_W-1:0] err;
    } t_entry;

endpackage

// ===== design/least_loaded_server_select.sv =====
// top level: server table with health reports, completions and least-loaded select
//
// usage
//   request channel: start is sampled at a rising edge; a request is taken when start is
//   high and busy is low. i_command picks a health report, a completion or a select;
//   i_server_index, i_healthy, i_error_count and i_served_count go with it.
//   result channel: a select answers with o_result_valid high for exactly one cycle,
//   carrying o_chosen_server and o_none_healthy. the receiver cannot stall; the result
//   is gone after that cycle.
//   config: i_cfg_we writes i_cfg_wdata into servers_in_use; write only while idle.
// timing
//   health report: taken in the request cycle, busy never rises
//   completion: count read in the request cycle, written back plus one while busy
//   select: busy while it scans N = min(servers_in_use, MAX_SERVERS) entries, one per
//   cycle through the single read port of the count table; result in the cycle after
//   the last one. with N = 0 the result shows in the cycle after the request.
// reset
//   synchronous, active low: servers_in_use back to 1, all entries unhealthy and their
//   counts read as zero until written (per-entry written bits), no result pending
module least_loaded_server_select
    import llss_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [IDX_W-1:0] i_server_index,
    input  logic             i_healthy,
    input  logic [CNT_W-1:0] i_error_count,
    input  logic [CNT_W-1:0] i_served_count,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_result_valid,
    output logic [IDX_W-1:0] o_chosen_server,
    output logic             o_none_healthy
);

    // table address width, width able to hold the table size, common compare width
    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int AW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [AW-1:0] MAX_AW = AW'(MAX_SERVERS);

    // state
    t_state r_state, n_state;

    // config register
    logic [CFG_W-1:0] r_servers_in_use;

    // per-entry flags: healthy, and written since reset
    logic [MAX_SERVERS-1:0] r_healthy;
    logic [MAX_SERVERS-1:0] r_written;

    // count table with one read and one write port
    t_entry mem [MAX_SERVERS];
    t_entry r_rd_data;
    logic   r_rd_written;

    // request held for the completion write
    logic [IW-1:0] r_addr;
    logic          r_addr_ok;

    // scan state: current entry and running best
    logic [IW-1:0]    r_scan, n_scan;
    logic             r_found, n_found;
    logic [IW-1:0]    r_best, n_best;
    logic [CNT_W-1:0] r_low, n_low;
    logic [CNT_W-1:0] r_best_err, n_best_err;

    // result registers
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_chosen, n_chosen;
    logic             r_none, n_none;

    // combinational helpers
    logic [AW-1:0]    active;
    logic [AW-1:0]    idx_ext;
    logic [IW-1:0]    idx_addr;
    logic             idx_ok;
    logic             accept;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic             hflag_we;
    t_entry           rd_entry;
    logic             cur_healthy;
    logic             take;
    logic             tie;
    logic             last;
    logic [AW-1:0]    best_ext;

    // entries taking part: register clamped to the table size
    assign active   = (AW'(r_servers_in_use) > MAX_AW) ? MAX_AW : AW'(r_servers_in_use);
    assign idx_ext  = AW'(i_server_index);
    assign idx_addr = idx_ext[IW-1:0];
    assign idx_ok   = idx_ext < active;
    assign accept   = start && !busy;

    // entries never written read as zero counts
    assign rd_entry = r_rd_written ? r_rd_data : '0;

    // scan compare: first healthy entry always taken, lower count wins,
    // equal count moves on only for strictly more errors
    assign cur_healthy = r_healthy[r_scan];
    assign take = cur_healthy && (!r_found || (rd_entry.req < r_low));
    assign tie  = cur_healthy && r_found && (rd_entry.req == r_low)
                  && (rd_entry.err > r_best_err);
    assign last = ((AW'(r_scan) + AW'(1)) == active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_found     = r_found;
        n_best      = r_best;
        n_low       = r_low;
        n_best_err  = r_best_err;
        n_out_valid = 1'b0;
        n_chosen    = r_chosen;
        n_none      = r_none;
        rd_addr     = idx_addr;
        mem_we      = 1'b0;
        mem_waddr   = idx_addr;
        mem_wdata   = '{req: i_served_count, err: i_error_count};
        hflag_we    = 1'b0;
        best_ext    = '0;
        busy        = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        CMD_REPORT: begin
                            // report written in the request cycle
                            mem_we   = idx_ok;
                            hflag_we = idx_ok;
                        end
                        CMD_DONE: begin
                            n_state = ST_DONE_WR;
                        end
                        CMD_SELECT: begin
                            rd_addr = '0;
                            n_scan  = '0;
                            n_found = 1'b0;
                            n_best  = '0;
                            if (active == '0) begin
                                // no entry in use: answer at once
                                n_out_valid = 1'b1;
                                n_chosen    = '0;
                                n_none      = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused code: no effect
                        end
                    endcase
                end
            end
            ST_DONE_WR: begin
                // saturating increment of the addressed count
                mem_we    = r_addr_ok;
                mem_waddr = r_addr;
                mem_wdata.err = rd_entry.err;
                mem_wdata.req = (rd_entry.req == COUNT_MAX) ? rd_entry.req
                                                            : rd_entry.req + CNT_W'(1);
                rd_addr   = r_addr;
                n_state   = ST_IDLE;
            end
            ST_SCAN: begin
                // read one entry ahead; the wrapped address past the end is never used
                rd_addr = r_scan + IW'(1);
                if (take || tie) begin
                    n_best     = r_scan;
                    n_best_err = rd_entry.err;
                end
                if (take) begin
                    n_found = 1'b1;
                    n_low   = rd_entry.req;
                end
                n_scan = r_scan + IW'(1);
                if (last) begin
                    best_ext    = AW'(n_best);
                    n_out_valid = 1'b1;
                    n_chosen    = best_ext[IDX_W-1:0];
                    n_none      = !n_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers_in_use <= SERVERS_IN_USE_RST;
            r_healthy        <= '0;
            r_written        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_servers_in_use <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_written[mem_waddr] <= 1'b1;
            end
            if (hflag_we) begin
                r_healthy[idx_addr] <= i_healthy;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_found    <= n_found;
        r_best     <= n_best;
        r_low      <= n_low;
        r_best_err <= n_best_err;
        r_chosen   <= n_chosen;
        r_none     <= n_none;
        if (accept) begin
            r_addr    <= idx_addr;
            r_addr_ok <= idx_ok;
        end
    end

    // count table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data    <= mem[rd_addr];
        r_rd_written <= r_written[rd_addr];
    end

    assign o_result_valid  = r_out_valid;
    assign o_chosen_server = r_chosen;
    assign o_none_healthy  = r_none;

endmodule

// ===== design/llss_checker.sv =====
// port-level checker for least_loaded_server_select, bound to the top level
module llss_checker
    import llss_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [CMD_W-1:0] i_command,
    input logic             o_result_valid,
    input logic [IDX_W-1:0] o_chosen_server,
    input logic             o_none_healthy
);

    // a result only shows once the scan has ended
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // no healthy entry means server 0
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_none_healthy) |-> (o_chosen_server == '0))
        else $error("none healthy with nonzero server");

    // report and unused code: no busy time and no result
    a_report_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_REPORT || i_command == CMD_UNUSED))
        |=> (!busy && !o_result_valid))
        else $error("report caused busy or result");

    // completion: busy after the request, never a result
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_DONE) |=> (busy && !o_result_valid))
        else $error("completion timing wrong");

    // select either scans or answers at once
    a_select_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_SELECT) |=> (busy || o_result_valid))
        else $error("select dropped");

endmodule

bind least_loaded_server_select llss_checker u_llss_checker (.*);

// ===== sim/least_loaded_server_select_checker.sv =====
// request and result monitor with server table prediction for least_loaded_server_select
`timescale 1ns / 100ps

module least_loaded_server_select_checker
    import llss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [IDX_W-1:0] i_server_index,
    input  logic             i_healthy,
    input  logic [CNT_W-1:0] i_error_count,
    input  logic [CNT_W-1:0] i_served_count,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_result_valid,
    input  logic [IDX_W-1:0] i_chosen_server,
    input  logic             i_none_healthy,
    output int               o_fail_count,
    output int               o_picks_pending,
    output int               o_picks_checked
);

    typedef struct packed {
        logic [IDX_W-1:0] server;
        logic             none;
    } t_pick;

    logic [CFG_W-1:0] in_use;
    logic             table_healthy [MAX_SERVERS_DEF];
    logic [CNT_W-1:0] table_served  [MAX_SERVERS_DEF];
    logic [CNT_W-1:0] table_errors  [MAX_SERVERS_DEF];
    t_pick            expected_picks [$];
    int               fails   = 0;
    int               checked = 0;

    function automatic int active_entries();
        if (int'(in_use) > MAX_SERVERS_DEF) begin
            return MAX_SERVERS_DEF;
        end
        return int'(in_use);
    endfunction

    // ascending scan; equal counts move on only to an entry with strictly more errors
    function automatic t_pick pick_least_loaded();
        t_pick            pick;
        logic             found;
        logic [CNT_W-1:0] lowest;
        found       = 1'b0;
        lowest      = '0;
        pick.server = '0;
        for (int k = 0; k < active_entries(); k++) begin
            if (table_healthy[k]) begin
                if (!found || table_served[k] < lowest) begin
                    found       = 1'b1;
                    pick.server = IDX_W'(k);
                    lowest      = table_served[k];
                end else if (table_served[k] == lowest &&
                             table_errors[k] > table_errors[pick.server]) begin
                    pick.server = IDX_W'(k);
                end
            end
        end
        pick.none = !found;
        return pick;
    endfunction

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            in_use = SERVERS_IN_USE_RST;
            for (int k = 0; k < MAX_SERVERS_DEF; k++) begin
                table_healthy[k] = 1'b0;
                table_served[k]  = '0;
                table_errors[k]  = '0;
            end
            expected_picks.delete();
        end else begin
            if (i_result_valid) begin
                if (expected_picks.size() == 0) begin
                    $error("unexpected result: chosen_server %0d none_healthy %0d",
                           i_chosen_server, i_none_healthy);
                    fails++;
                end else begin
                    want = expected_picks.pop_front();
                    checked++;
                    if (i_chosen_server !== want.server) begin
                        $error("chosen_server: expected %0d, got %0d",
                               want.server, i_chosen_server);
                        fails++;
                    end
                    if (i_none_healthy !== want.none) begin
                        $error("none_healthy: expected %0d, got %0d",
                               want.none, i_none_healthy);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                in_use = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                case (i_command)
                    CMD_REPORT: begin
                        if (int'(i_server_index) < active_entries()) begin
                            table_healthy[i_server_index] = i_healthy;
                            table_errors[i_server_index]  = i_error_count;
                            table_served[i_server_index]  = i_served_count;
                        end
                    end
                    CMD_DONE: begin
                        if (int'(i_server_index) < active_entries() &&
                            table_served[i_server_index] != COUNT_MAX) begin
                            table_served[i_server_index] += 1;
                        end
                    end
                    CMD_SELECT: expected_picks.push_back(pick_least_loaded());
                    default: ;
                endcase
            end
        end
        o_picks_pending <= expected_picks.size();
        o_fail_count    <= fails;
        o_picks_checked <= checked;
    end

endmodule

// ===== sim/least_loaded_server_select_test.sv =====
// top of the least_loaded_server_select testbench: clock, reset, request stimulus, verdict
`timescale 1ns / 100ps

module least_loaded_server_select_test;
    import llss_pkg::*;

    localparam int TARGET_REQUESTS = 950;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] i_command      = CMD_REPORT;
    logic [IDX_W-1:0] i_server_index = '0;
    logic             i_healthy      = 1'b0;
    logic [CNT_W-1:0] i_error_count  = '0;
    logic [CNT_W-1:0] i_served_count = '0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata    = '0;
    logic             o_result_valid;
    logic [IDX_W-1:0] o_chosen_server;
    logic             o_none_healthy;

    int fail_count;
    int picks_pending;
    int picks_checked;

    // top-side bookkeeping: current table size and what the stimulus has reached
    logic [CFG_W-1:0] cur_in_use   = SERVERS_IN_USE_RST;
    int               counted      = 0;
    int               sent_total   = 0;
    int               sizes_tried  = 0;
    logic             no_idle      = 1'b0;

    always #5 i_clk = ~i_clk;

    least_loaded_server_select dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_server_index (i_server_index),
        .i_healthy      (i_healthy),
        .i_error_count  (i_error_count),
        .i_served_count (i_served_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_chosen_server(o_chosen_server),
        .o_none_healthy (o_none_healthy)
    );

    least_loaded_server_select_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_server_index (i_server_index),
        .i_healthy      (i_healthy),
        .i_error_count  (i_error_count),
        .i_served_count (i_served_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_result_valid (o_result_valid),
        .i_chosen_server(o_chosen_server),
        .i_none_healthy (o_none_healthy),
        .o_fail_count   (fail_count),
        .o_picks_pending(picks_pending),
        .o_picks_checked(picks_checked)
    );

    // entries that take part; anything above the table size acts as the full table
    function automatic int active_entries();
        return (int'(cur_in_use) > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : int'(cur_in_use);
    endfunction

    // present one request and hold it until the block takes it;
    // start is left high so a back-to-back request needs no second assignment
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic hl, input logic [CNT_W-1:0] errs,
                                input logic [CNT_W-1:0] served);
        start          <= 1'b1;
        i_command      <= cmd;
        i_server_index <= idx;
        i_healthy      <= hl;
        i_error_count  <= errs;
        i_served_count <= served;
        do @(posedge i_clk); while (busy);
        sent_total++;
        // tally of requests that the block acts on, for the summary
        if (cmd == CMD_SELECT || (cmd != CMD_UNUSED && int'(idx) < active_entries())) begin
            counted++;
        end
    endtask

    // sender gap: mostly none or short, now and then long
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            n = 0;
        end else if (r < 85) begin
            n = $urandom_range(1, 3);
        end else if (r < 95) begin
            n = $urandom_range(4, 10);
        end else begin
            n = $urandom_range(20, 60);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drop start, wait for every pick to come back and a trailing completion to finish
    task automatic wait_all_picks();
        start <= 1'b0;
        @(posedge i_clk);
        while (picks_pending != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_servers_in_use(input logic [CFG_W-1:0] value);
        wait_all_picks();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_in_use  = value;
        sizes_tried++;
    endtask

    // counts: mostly tiny so ties and error tie-breaks happen, some near full scale
    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return CNT_W'($urandom_range(0, 3));
        end else if (r < 8) begin
            return COUNT_MAX - CNT_W'($urandom_range(0, 2));
        end
        return CNT_W'($urandom);
    endfunction

    task automatic random_phase(input int phase_target);
        int               r;
        int               stop_at;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] size;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            size = '0;
        end else if (r == 1) begin
            size = CFG_W'($urandom_range(17, 31));
        end else if (r == 2) begin
            size = 5'd1;
        end else if (r == 3) begin
            size = 5'd16;
        end else begin
            size = CFG_W'($urandom_range(2, 15));
        end
        write_servers_in_use(size);
        no_idle = ($urandom_range(0, 3) == 0);
        stop_at = sent_total + phase_target;
        if (stop_at > TARGET_REQUESTS) begin
            stop_at = TARGET_REQUESTS;
        end
        while (sent_total < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                cmd = CMD_REPORT;
            end else if (r < 65) begin
                cmd = CMD_DONE;
            end else if (r < 95) begin
                cmd = CMD_SELECT;
            end else begin
                cmd = CMD_UNUSED;
            end
            // mostly aim at live entries, sometimes anywhere in the index range
            if (active_entries() > 0 && $urandom_range(0, 9) < 8) begin
                idx = IDX_W'($urandom_range(0, active_entries() - 1));
            end else begin
                idx = IDX_W'($urandom_range(0, 15));
            end
            send_request(cmd, idx, ($urandom_range(0, 9) < 7), pick_count(), pick_count());
            sender_gap();
        end
    endtask

    // watchdog, far beyond the slowest passing run
    initial begin
        #5000000;
        $display("least_loaded_server_select_test: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table at the reset size: nobody healthy
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);

        write_servers_in_use(5'd16);
        // first healthy entry wins even at the largest count; completion saturates
        send_request(CMD_REPORT, 4'd0, 1'b1, COUNT_MAX, COUNT_MAX);
        send_request(CMD_DONE, 4'd0, 1'b0, '0, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        // lower count at the last entry
        send_request(CMD_REPORT, 4'd15, 1'b1, '0, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        // equal counts: later entry taken only with strictly more errors
        send_request(CMD_REPORT, 4'd5, 1'b1, 32'd10, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        send_request(CMD_REPORT, 4'd3, 1'b1, 32'd5, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        send_request(CMD_DONE, 4'd5, 1'b0, '0, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        // unused command code and an unhealthy report
        send_request(CMD_UNUSED, 4'd3, 1'b1, COUNT_MAX, COUNT_MAX);
        send_request(CMD_REPORT, 4'd3, 1'b0, 32'd5, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);

        // zero entries in use: everything ignored, select reports none healthy
        write_servers_in_use(5'd0);
        send_request(CMD_REPORT, 4'd0, 1'b1, '0, '0);
        send_request(CMD_DONE, 4'd0, 1'b0, '0, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);

        // above the table size acts as the full table
        write_servers_in_use(5'd31);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);

        // shrunk table: entries beyond it are ignored but keep their contents
        write_servers_in_use(5'd4);
        send_request(CMD_REPORT, 4'd10, 1'b1, '0, '0);
        send_request(CMD_DONE, 4'd15, 1'b0, '0, '0);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);
        write_servers_in_use(5'd16);
        send_request(CMD_SELECT, 4'd0, 1'b0, '0, '0);

        // random phases, each at its own table size
        while (sent_total < TARGET_REQUESTS) begin
            random_phase($urandom_range(60, 120));
        end

        wait_all_picks();
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests (%0d counted), %0d picks checked, %0d table sizes",
                 sent_total, counted, picks_checked, sizes_tried);
        $display("table sizes included zero, one, full and above the table size");
        if (fail_count == 0) begin
            $display("least_loaded_server_select_test: clean");
        end else begin
            $display("least_loaded_server_select_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/llss_pkg.sv
design/least_loaded_server_select.sv
design/llss_checker.sv
sim/least_loaded_server_select_checker.sv
sim/least_loaded_server_select_test.sv
